### hw/rtl/sstw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sstw_pkg
// Shared types, command codes and the character-to-segment encoder of the
// seven-segment two-wire digit writer.
// ----------------------------------------------------------------------------
package sstw_pkg;

   // item commands
   localparam logic CMD_SHOW = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam int unsigned CSR_DATA_WIDTH  = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_BRIGHTNESS = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DP_ENABLE  = 1'd1;
   localparam logic [2:0] BRIGHTNESS_RESET = 3'd5;

   // sequence steps: 0 is idle, 1..10 walk the three transfers
   localparam logic [3:0] STEP_IDLE     = 4'd0;
   localparam logic [3:0] STEP_START_A  = 4'd1;
   localparam logic [3:0] STEP_DATA_CMD = 4'd2;
   localparam logic [3:0] STEP_STOP_A   = 4'd3;
   localparam logic [3:0] STEP_START_B  = 4'd4;
   localparam logic [3:0] STEP_ADDR     = 4'd5;
   localparam logic [3:0] STEP_SEGS     = 4'd6;
   localparam logic [3:0] STEP_STOP_B   = 4'd7;
   localparam logic [3:0] STEP_START_C  = 4'd8;
   localparam logic [3:0] STEP_CTRL     = 4'd9;
   localparam logic [3:0] STEP_STOP_C   = 4'd10;

   // bytes sent on the wire
   localparam logic [7:0] BYTE_DATA_CMD  = 8'h44;
   localparam logic [5:0] BYTE_ADDR_HIGH = 6'b110000;  // 0xC0 with position below
   localparam logic [4:0] BYTE_CTRL_HIGH = 5'b10001;   // 0x88 with brightness below

   localparam logic [7:0] CHAR_BLANK = 8'h7f;
   localparam logic [7:0] ASCII_ZERO = 8'd48;
   localparam logic [7:0] ASCII_NINE = 8'd57;
   localparam logic [7:0] SEG_POINT  = 8'h80;

   localparam logic [7:0] HEX_SEGMENTS [16] = '{
      8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
      8'h7f, 8'h6f, 8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71
   };

   typedef struct packed {
      logic       cmd;
      logic [1:0] digit_position;
      logic [7:0] char_code;
      logic       data_pin_level;
   } req_item_type;

   typedef struct packed {
      logic clock_level;
      logic data_level;
      logic data_drive;
      logic busy_res;
      logic ack_missing;
   } pin_state_type;

   function automatic logic [7:0] encode_segments(input logic [7:0] c, input logic point);
      logic [7:0] s;
      logic [7:0] d;
      d = c - ASCII_ZERO;
      if (c == CHAR_BLANK) begin
         s = 8'h00;
      end else if (c < 8'd16) begin
         s = HEX_SEGMENTS[c[3:0]];
      end else if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
         s = HEX_SEGMENTS[d[3:0]];
      end else begin
         case (c)
            "_":     s = 8'h08;
            "^":     s = 8'h01;
            "-":     s = 8'h40;
            "*":     s = 8'h63;
            "A":     s = 8'h77;
            "b":     s = 8'h7c;
            "c":     s = 8'h58;
            "C":     s = 8'h39;
            "d":     s = 8'h5e;
            "E":     s = 8'h79;
            "F":     s = 8'h71;
            "h":     s = 8'h74;
            "H":     s = 8'h76;
            "I":     s = 8'h30;
            "J":     s = 8'h0e;
            "L":     s = 8'h38;
            "n":     s = 8'h54;
            "N":     s = 8'h37;
            "o":     s = 8'h5c;
            "P":     s = 8'h73;
            "q":     s = 8'h67;
            "u":     s = 8'h1c;
            "U":     s = 8'h3e;
            "y":     s = 8'h66;
            default: s = 8'h00;
         endcase
      end
      return point ? (s | SEG_POINT) : s;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/sstw_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sstw_ifs
// Valid/ready channels of the digit writer: request items in, pin items out.
// ----------------------------------------------------------------------------
interface sstw_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [1:0] digit_position;
   logic [7:0] char_code;
   logic       data_pin_level;

   modport source (output valid, cmd, digit_position, char_code, data_pin_level,
                   input ready);
   modport sink   (input valid, cmd, digit_position, char_code, data_pin_level,
                   output ready);
endinterface

interface sstw_rsp_if;
   logic valid;
   logic ready;
   logic clock_level;
   logic data_level;
   logic data_drive;
   logic busy_res;
   logic ack_missing;

   modport source (output valid, clock_level, data_level, data_drive, busy_res,
                   ack_missing, input ready);
   modport sink   (input valid, clock_level, data_level, data_drive, busy_res,
                   ack_missing, output ready);
endinterface
`default_nettype wire

### hw/rtl/sstw_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sstw_seq
// Pin sequencer: holds the line state and works out the effect of one item.
// ----------------------------------------------------------------------------
module sstw_seq (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   adv,
   input  wire sstw_pkg::req_item_type item,
   input  wire logic [2:0]             brightness,
   input  wire logic                   dp_enable,
   output sstw_pkg::pin_state_type     cur_pins,
   output sstw_pkg::pin_state_type     nxt_pins
);
   import sstw_pkg::*;

   logic [3:0] step_ff,  step_in;
   logic [3:0] bit_ff,   bit_in;
   logic [2:0] phase_ff, phase_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] seg_ff,   seg_in;
   logic [1:0] pos_ff,   pos_in;
   logic       clk_ff,   clk_in;
   logic       dat_ff,   dat_in;
   logic       drv_ff,   drv_in;
   logic       ack_ff,   ack_in;
   logic       enter;
   logic [3:0] next_step;

   always_comb begin
      step_in   = step_ff;
      bit_in    = bit_ff;
      phase_in  = phase_ff;
      shift_in  = shift_ff;
      seg_in    = seg_ff;
      pos_in    = pos_ff;
      clk_in    = clk_ff;
      dat_in    = dat_ff;
      drv_in    = drv_ff;
      ack_in    = ack_ff;
      enter     = 1'b0;
      next_step = step_ff + 4'd1;

      if (item.cmd == CMD_SHOW) begin
         // a request is dropped unless the writer is idle
         if (step_ff == STEP_IDLE) begin
            pos_in    = item.digit_position;
            seg_in    = encode_segments(item.char_code, dp_enable);
            ack_in    = 1'b0;
            enter     = 1'b1;
            next_step = STEP_START_A;
         end
      end else if (step_ff != STEP_IDLE) begin
         if (step_ff inside {STEP_START_A, STEP_START_B, STEP_START_C}) begin
            phase_in = phase_ff + 3'd1;
            case (phase_ff)
               3'd0:    clk_in = 1'b1;
               3'd1:    dat_in = 1'b1;
               3'd2:    dat_in = 1'b0;
               default: begin
                  clk_in = 1'b0;
                  enter  = 1'b1;
               end
            endcase
         end else if (step_ff inside {STEP_STOP_A, STEP_STOP_B, STEP_STOP_C}) begin
            phase_in = phase_ff + 3'd1;
            case (phase_ff)
               3'd0:    clk_in = 1'b0;
               3'd1:    dat_in = 1'b0;
               3'd2:    clk_in = 1'b1;
               default: begin
                  dat_in = 1'b1;
                  enter  = 1'b1;
               end
            endcase
         end else if (bit_ff < 4'd8) begin
            // three ticks a bit: clock low, data, clock high
            case (phase_ff)
               3'd0: begin
                  clk_in   = 1'b0;
                  phase_in = 3'd1;
               end
               3'd1: begin
                  dat_in   = shift_ff[0];
                  shift_in = {1'b0, shift_ff[7:1]};
                  phase_in = 3'd2;
               end
               default: begin
                  clk_in   = 1'b1;
                  phase_in = 3'd0;
                  bit_in   = bit_ff + 4'd1;
               end
            endcase
         end else if (bit_ff == 4'd8) begin
            case (phase_ff)
               3'd0: begin
                  clk_in   = 1'b0;
                  phase_in = 3'd1;
               end
               3'd1: begin
                  dat_in   = 1'b1;
                  phase_in = 3'd2;
               end
               3'd2: begin
                  clk_in   = 1'b1;
                  phase_in = 3'd3;
               end
               3'd3: begin
                  drv_in   = 1'b0;
                  phase_in = 3'd4;
               end
               3'd4: begin
                  // sample the ack; high means nobody pulled the line
                  if (item.data_pin_level) begin
                     ack_in   = 1'b1;
                     bit_in   = 4'd9;
                     phase_in = 3'd0;
                  end else begin
                     phase_in = 3'd5;
                  end
               end
               3'd5: begin
                  drv_in   = 1'b1;
                  phase_in = 3'd6;
               end
               default: begin
                  dat_in   = 1'b0;
                  bit_in   = 4'd9;
                  phase_in = 3'd0;
               end
            endcase
         end else begin
            case (phase_ff)
               3'd0:    phase_in = 3'd1;
               3'd1: begin
                  drv_in   = 1'b1;
                  phase_in = 3'd2;
               end
               default: enter = 1'b1;
            endcase
         end
      end

      if (enter) begin
         phase_in = 3'd0;
         bit_in   = 4'd0;
         if (next_step > STEP_STOP_C) begin
            step_in = STEP_IDLE;
         end else begin
            step_in = next_step;
            case (next_step)
               STEP_DATA_CMD: shift_in = BYTE_DATA_CMD;
               STEP_ADDR:     shift_in = {BYTE_ADDR_HIGH, pos_ff};
               STEP_SEGS:     shift_in = seg_ff;
               STEP_CTRL:     shift_in = {BYTE_CTRL_HIGH, brightness};
               default:       shift_in = shift_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= STEP_IDLE;
         bit_ff   <= 4'd0;
         phase_ff <= 3'd0;
         shift_ff <= 8'h00;
         clk_ff   <= 1'b1;
         dat_ff   <= 1'b1;
         drv_ff   <= 1'b1;
         ack_ff   <= 1'b0;
      end else if (adv) begin
         step_ff  <= step_in;
         bit_ff   <= bit_in;
         phase_ff <= phase_in;
         shift_ff <= shift_in;
         clk_ff   <= clk_in;
         dat_ff   <= dat_in;
         drv_ff   <= drv_in;
         ack_ff   <= ack_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         seg_ff <= seg_in;
         pos_ff <= pos_in;
      end
   end

   assign cur_pins = '{clock_level: clk_ff, data_level: dat_ff, data_drive: drv_ff,
                       busy_res: (step_ff != STEP_IDLE), ack_missing: ack_ff};
   assign nxt_pins = '{clock_level: clk_in, data_level: dat_in, data_drive: drv_in,
                       busy_res: (step_in != STEP_IDLE), ack_missing: ack_in};

endmodule
`default_nettype wire

### hw/rtl/seven_segment_two_wire_digit_writer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seven_segment_two_wire_digit_writer
// Writes one digit to a two-wire seven-segment display controller.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries items: a show item (cmd 0) with a position and a character
//   code starts a write sequence; a tick item (cmd 1) performs the next pin
//   action and carries the sampled data pin for the ack. Show items that
//   arrive while a sequence runs are dropped; ticks while idle change nothing.
//   rsp_bus returns one item per request item with the clock and data line
//   levels, the data drive enable, busy and the missing-ack flag.
//   csr_we/csr_index/csr_wdata set brightness (index 0) and the decimal point
//   (index 1); write them only while the block is idle.
// Timing:
//   An item passes an input register and an output register to its result.
//   One item is taken every cycle while the output is not stalled; the
//   sequencer update between the two registers is the only work per item.
// Reset:
//   Synchronous, active high. Lines come up high and driven, sequencer idle,
//   brightness 5, point off, both channel stages empty.
// Stall:
//   With rsp_bus.ready low the result holds; one more item is taken into the
//   input register, then req_bus.ready drops until the result drains.
// ----------------------------------------------------------------------------
module seven_segment_two_wire_digit_writer (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   sstw_req_if.sink                                   req_bus,
   sstw_rsp_if.source                                 rsp_bus,
   input  wire logic                                  csr_we,
   input  wire logic [sstw_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [sstw_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import sstw_pkg::*;

   logic          bright_ff;
   logic [2:0]    brightness_ff;
   logic          point_ff;
   logic          in_valid_ff;
   req_item_type  in_item_ff;
   logic          out_valid_ff;
   pin_state_type out_pins_ff;
   logic          adv;
   logic          in_ready;
   pin_state_type cur_pins;
   pin_state_type nxt_pins;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= BRIGHTNESS_RESET;
         point_ff      <= 1'b0;
         bright_ff     <= 1'b0;
      end else begin
         bright_ff <= 1'b0;
         if (csr_we) begin
            case (csr_index)
               REG_BRIGHTNESS: begin
                  brightness_ff <= csr_wdata[2:0];
                  bright_ff     <= 1'b1;
               end
               REG_DP_ENABLE:  point_ff <= csr_wdata[0];
               default:        ;
            endcase
         end
      end
   end

   // advance the held item into the sequencer when the output slot frees up
   assign adv      = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign in_ready = !in_valid_ff || adv;
   assign req_bus.ready = in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            in_valid_ff <= req_bus.valid;
         end
         if (adv) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_bus.valid) begin
         in_item_ff <= '{cmd: req_bus.cmd, digit_position: req_bus.digit_position,
                         char_code: req_bus.char_code,
                         data_pin_level: req_bus.data_pin_level};
      end
      if (adv) begin
         out_pins_ff <= nxt_pins;
      end
   end

   sstw_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .item       (in_item_ff),
      .brightness (brightness_ff),
      .dp_enable  (point_ff),
      .cur_pins   (cur_pins),
      .nxt_pins   (nxt_pins)
   );

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.clock_level = out_pins_ff.clock_level;
   assign rsp_bus.data_level  = out_pins_ff.data_level;
   assign rsp_bus.data_drive  = out_pins_ff.data_drive;
   assign rsp_bus.busy_res    = out_pins_ff.busy_res;
   assign rsp_bus.ack_missing = out_pins_ff.ack_missing;

   // an idle writer leaves both lines high and driven
   a_idle_lines: assert property (@(posedge clock) disable iff (reset)
      !cur_pins.busy_res |-> (cur_pins.clock_level && cur_pins.data_level &&
                              cur_pins.data_drive))
      else $error("idle writer with a line low or released");

   // a held item never disappears without moving on
   a_hold_item: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !adv) |=> in_valid_ff)
      else $error("input item dropped while stalled");

   // every advance lands a result in the output register
   a_adv_result: assert property (@(posedge clock) disable iff (reset)
      adv |=> out_valid_ff)
      else $error("advance without a result");

   // brightness writes land only on their own index
   a_csr_bright: assert property (@(posedge clock) disable iff (reset)
      bright_ff |-> ($past(csr_we) && $past(csr_index) == REG_BRIGHTNESS))
      else $error("brightness changed by another register write");

endmodule
`default_nettype wire
